/* sv/script_token_lexer_macros.svh */
// Assertion macros for the script token lexer checker.
// Depends on nothing; the including module supplies clock and reset.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

// Checked only outside reset.
`define STL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define STL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/stl_pkg.sv */
// Shared types and constants for the script token lexer.
// Depends on nothing; every module file imports it.
package stl_pkg;

   localparam int POSITION_BITS = 16;
   localparam int FIELD_BITS    = 16;
   localparam int TYPE_BITS     = 6;

   localparam int RSP_PTR_BITS  = 2;
   localparam int RSP_DEPTH     = 1 << RSP_PTR_BITS;
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   localparam logic [TYPE_BITS-1:0] TOK_END     = 6'd0;
   localparam logic [TYPE_BITS-1:0] TOK_ILLEGAL = 6'd1;
   localparam logic [TYPE_BITS-1:0] TOK_SEMI    = 6'd2;
   localparam logic [TYPE_BITS-1:0] TOK_COMMA   = 6'd3;
   localparam logic [TYPE_BITS-1:0] TOK_BANG    = 6'd4;
   localparam logic [TYPE_BITS-1:0] TOK_STAR    = 6'd5;
   localparam logic [TYPE_BITS-1:0] TOK_SLASH   = 6'd6;
   localparam logic [TYPE_BITS-1:0] TOK_PERCENT = 6'd7;
   localparam logic [TYPE_BITS-1:0] TOK_GT      = 6'd8;
   localparam logic [TYPE_BITS-1:0] TOK_LT      = 6'd9;
   localparam logic [TYPE_BITS-1:0] TOK_LPAREN  = 6'd10;
   localparam logic [TYPE_BITS-1:0] TOK_RPAREN  = 6'd11;
   localparam logic [TYPE_BITS-1:0] TOK_LBRACE  = 6'd12;
   localparam logic [TYPE_BITS-1:0] TOK_RBRACE  = 6'd13;
   localparam logic [TYPE_BITS-1:0] TOK_LBRACK  = 6'd14;
   localparam logic [TYPE_BITS-1:0] TOK_RBRACK  = 6'd15;
   localparam logic [TYPE_BITS-1:0] TOK_PLUS    = 6'd16;
   localparam logic [TYPE_BITS-1:0] TOK_MINUS   = 6'd17;
   localparam logic [TYPE_BITS-1:0] TOK_ASSIGN  = 6'd18;
   localparam logic [TYPE_BITS-1:0] TOK_EQ      = 6'd19;
   localparam logic [TYPE_BITS-1:0] TOK_NOT_EQ  = 6'd20;
   localparam logic [TYPE_BITS-1:0] TOK_INT     = 6'd21;
   localparam logic [TYPE_BITS-1:0] TOK_STRING  = 6'd22;
   localparam logic [TYPE_BITS-1:0] TOK_IDENT   = 6'd23;
   localparam logic [TYPE_BITS-1:0] TOK_KW_BASE = 6'd24;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_marker;
   } req_type;

   typedef struct packed {
      logic [TYPE_BITS-1:0]  token_type;
      logic [FIELD_BITS-1:0] token_start;
      logic [FIELD_BITS-1:0] token_length;
      logic                  last_in_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

/* sv/stl_step.sv */
// Lexer state registers and the per-byte step logic.
// Depends on stl_pkg; feeds up to two tokens a word into the result queue.
module stl_step import stl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     consume,
   input  req_type  item,
   output push_type push
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_STRING  = 3'd2;
   localparam logic [2:0] MODE_IDENT   = 3'd3;
   localparam logic [2:0] MODE_INT     = 3'd4;
   localparam logic [2:0] MODE_EQ      = 3'd5;
   localparam logic [2:0] MODE_BANG    = 3'd6;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_QUERY = 8'h3F;

   localparam int KW_COUNT = 10;
   localparam logic [47:0] KW_PACK [KW_COUNT] = '{
      48'h00000076616C, 48'h000000766172, 48'h00000000666E, 48'h72657475726E,
      48'h000000006966, 48'h0000656C7365, 48'h007768696C65, 48'h000074727565,
      48'h0066616C7365, 48'h0000004E494C
   };

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] p);
      return (p == POS_MAX) ? p : p + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [POSITION_BITS-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[FIELD_BITS-1:0];
   endfunction

   function automatic logic [TYPE_BITS-1:0] punct_type(input logic [7:0] c);
      logic [TYPE_BITS-1:0] t;
      case (c)
         8'h3B: t = TOK_SEMI;
         8'h2C: t = TOK_COMMA;
         8'h2A: t = TOK_STAR;
         8'h2F: t = TOK_SLASH;
         8'h25: t = TOK_PERCENT;
         8'h3E: t = TOK_GT;
         8'h3C: t = TOK_LT;
         8'h28: t = TOK_LPAREN;
         8'h29: t = TOK_RPAREN;
         8'h7B: t = TOK_LBRACE;
         8'h7D: t = TOK_RBRACE;
         8'h5B: t = TOK_LBRACK;
         8'h5D: t = TOK_RBRACK;
         8'h2B: t = TOK_PLUS;
         8'h2D: t = TOK_MINUS;
         default: t = TOK_ILLEGAL;
      endcase
      return t;
   endfunction

   function automatic logic [TYPE_BITS-1:0] word_type(input logic [47:0] win,
                                                     input logic too_long);
      logic [TYPE_BITS-1:0] t;
      t = TOK_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (!too_long && win == KW_PACK[i]) begin
            t = TOK_KW_BASE + TYPE_BITS'(i);
         end
      end
      return t;
   endfunction

   function automatic rsp_type mk_tok(input logic [TYPE_BITS-1:0] t,
                                      input logic [FIELD_BITS-1:0] start,
                                      input logic [FIELD_BITS-1:0] len);
      rsp_type r;
      r.token_type   = t;
      r.token_start  = start;
      r.token_length = len;
      r.last_in_run  = 1'b0;
      return r;
   endfunction

   logic [2:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic [47:0]              window_ff, window_in;
   logic                     too_long_ff, too_long_in;

   logic [7:0]               c;
   logic [POSITION_BITS-1:0] p;
   logic [POSITION_BITS-1:0] span;

   logic                     flush_v;
   rsp_type                  flush_tok;

   logic                     idle_v;
   rsp_type                  idle_tok;
   logic [2:0]               idle_mode;
   logic                     idle_begin_v;
   logic [POSITION_BITS-1:0] idle_begin;
   logic                     idle_ident;
   logic                     idle_restart;

   logic                     use_idle;
   logic                     a_v, b_v;
   rsp_type                  a_tok, b_tok;

   assign c    = item.text_byte;
   assign p    = pos_ff;
   assign span = (p >= begin_ff) ? p - begin_ff : '0;

   always_comb begin
      flush_v   = 1'b1;
      flush_tok = mk_tok(TOK_STRING, to_field(begin_ff), to_field(span));
      case (mode_ff)
         MODE_STRING: flush_tok = mk_tok(TOK_STRING, to_field(begin_ff), to_field(span));
         MODE_IDENT:  flush_tok = mk_tok(word_type(window_ff, too_long_ff),
                                         to_field(begin_ff), to_field(span));
         MODE_INT:    flush_tok = mk_tok(TOK_INT, to_field(begin_ff), to_field(span));
         MODE_EQ:     flush_tok = mk_tok(TOK_ASSIGN, to_field(begin_ff), 16'd1);
         MODE_BANG:   flush_tok = mk_tok(TOK_BANG, to_field(begin_ff), 16'd1);
         default:     flush_v   = 1'b0;
      endcase
   end

   always_comb begin
      idle_v       = 1'b0;
      idle_tok     = mk_tok(punct_type(c), to_field(p), 16'd1);
      idle_mode    = MODE_IDLE;
      idle_begin_v = 1'b0;
      idle_begin   = p;
      idle_ident   = 1'b0;
      idle_restart = 1'b0;
      case (c)
         CH_SPACE, CH_LF, CH_TAB, CH_CR: idle_mode = MODE_IDLE;
         CH_HASH: idle_mode = MODE_COMMENT;
         CH_QUOTE: begin
            idle_mode    = MODE_STRING;
            idle_begin_v = 1'b1;
            idle_begin   = sat_inc(p);
         end
         CH_EQUAL: begin
            idle_mode    = MODE_EQ;
            idle_begin_v = 1'b1;
         end
         CH_BANG: begin
            idle_mode    = MODE_BANG;
            idle_begin_v = 1'b1;
         end
         CH_NUL: begin
            idle_v       = 1'b1;
            idle_tok     = mk_tok(TOK_END, to_field(p), 16'd0);
            idle_restart = 1'b1;
         end
         default: begin
            if (is_letter(c)) begin
               idle_mode    = MODE_IDENT;
               idle_begin_v = 1'b1;
               idle_ident   = 1'b1;
            end else if (is_digit(c)) begin
               idle_mode    = MODE_INT;
               idle_begin_v = 1'b1;
            end else begin
               idle_v = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = sat_inc(p);
      begin_in    = begin_ff;
      window_in   = window_ff;
      too_long_in = too_long_ff;
      use_idle    = 1'b0;
      a_v         = 1'b0;
      a_tok       = flush_tok;
      b_v         = 1'b0;
      b_tok       = idle_tok;

      if (item.end_marker) begin
         a_v         = flush_v;
         b_v         = 1'b1;
         b_tok       = mk_tok(TOK_END, to_field(p), 16'd0);
         mode_in     = MODE_IDLE;
         pos_in      = '0;
         begin_in    = '0;
         window_in   = '0;
         too_long_in = 1'b0;
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (c == CH_LF) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  a_v     = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_letter(c) || is_digit(c) || c == CH_QUERY) begin
                  if (window_ff[47:40] != 8'h00) begin
                     too_long_in = 1'b1;
                  end
                  window_in = {window_ff[39:0], c};
               end else begin
                  a_v      = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_INT: begin
               if (!is_digit(c)) begin
                  a_v      = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_EQ, MODE_BANG: begin
               if (c == CH_EQUAL) begin
                  b_v     = 1'b1;
                  b_tok   = mk_tok((mode_ff == MODE_EQ) ? TOK_EQ : TOK_NOT_EQ,
                                   to_field(begin_ff), 16'd2);
                  mode_in = MODE_IDLE;
               end else begin
                  a_v      = 1'b1;
                  use_idle = 1'b1;
               end
            end
            default: use_idle = 1'b1;
         endcase

         if (use_idle) begin
            b_v     = idle_v;
            mode_in = idle_mode;
            if (idle_begin_v) begin
               begin_in = idle_begin;
            end
            if (idle_ident) begin
               window_in   = {40'h0, c};
               too_long_in = 1'b0;
            end
            if (idle_restart) begin
               mode_in     = MODE_IDLE;
               pos_in      = '0;
               begin_in    = '0;
               window_in   = '0;
               too_long_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      push.count  = consume ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
      push.first  = a_v ? a_tok : b_tok;
      push.first.last_in_run = !(a_v && b_v);
      push.second = b_tok;
      push.second.last_in_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         begin_ff    <= '0;
         window_ff   <= '0;
         too_long_ff <= 1'b0;
      end else if (consume) begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         begin_ff    <= begin_in;
         window_ff   <= window_in;
         too_long_ff <= too_long_in;
      end
   end

endmodule

/* sv/stl_fifo.sv */
// Result queue: takes up to two tokens a cycle, hands out one a word.
// Depends on stl_pkg for the token and push types.
module stl_fifo import stl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     head_valid,
   output rsp_type  head,
   output logic     room
);

   rsp_type                 q_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [RSP_PTR_BITS-1:0] wr_next;

   assign wr_next    = wr_ptr_ff + 1'b1;
   assign head_valid = (count_ff != '0);
   assign head       = q_ff[rd_ptr_ff];
   assign room       = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_BITS'(pop);
      count_in  = count_ff + RSP_CNT_BITS'(push.count) - RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/script_token_lexer.sv */
// Top level of the script token lexer: input register, step logic, result queue.
// Depends on stl_pkg, stl_step and stl_fifo.
//
// Usage:
//   req channel carries one source byte, or an end marker, per word.
//   rsp channel carries one token per word: type, start offset, length,
//   and a flag on the last token caused by a given input word.
//   A byte gives zero, one or two tokens; a zero byte outside a string or
//   comment, or the end marker, gives END and restarts offsets at zero.
// Timing:
//   A request word is registered in the input register, stepped once the queue
//   has room, and its tokens are written into the queue, which offers them on rsp.
//   One request word is taken every cycle while the four-entry result queue
//   has room for two tokens; words that give two tokens fill the queue faster
//   than rsp drains it at one token a cycle, so the sustained rate is set by rsp.
// Reset:
//   Synchronous; clears the lexer state, the input register's valid flag and the queue pointers.
// Stall:
//   rsp_stall holds the head token; once the queue lacks room for two tokens
//   req_stall rises with the pending request word held in the input register.
module script_token_lexer import stl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type  in_ff;
   logic     in_valid_ff, in_valid_in;
   logic     room;
   logic     consume;
   logic     take;
   push_type push;

   assign consume     = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !consume;
   assign take        = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   stl_step u_step (
      .clock   (clock),
      .reset   (reset),
      .consume (consume),
      .item    (in_ff),
      .push    (push)
   );

   stl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_valid && !rsp_stall),
      .head_valid (rsp_valid),
      .head       (rsp_data),
      .room       (room)
   );

endmodule

/* sv/stl_checker.sv */
// Port-level checks for the script token lexer, bound to the top level.
// Depends on stl_pkg and script_token_lexer_macros.svh.
`include "script_token_lexer_macros.svh"
module stl_checker import stl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `STL_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp word changed while stalled")
   `STL_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "rsp valid straight after reset")
   `STL_ASSERT(a_end_shape, rsp_valid && rsp_data.token_type == TOK_END |-> rsp_data.token_length == 16'd0 && rsp_data.last_in_run, "END token malformed")
   `STL_ASSERT(a_pair_len, rsp_valid && (rsp_data.token_type == TOK_EQ || rsp_data.token_type == TOK_NOT_EQ) |-> rsp_data.token_length == 16'd2, "two-byte operator length wrong")

endmodule

bind script_token_lexer stl_checker u_checker (.*);
